[src/rws_pkg.sv]
`default_nettype none
// ============================================================================
// rws_pkg: shared types and constants of the recursive window smoother
// Field widths, register indexes and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package rws_pkg;

  // Coordinate width and the packed stream word.
  localparam int DATA_W  = 16;
  localparam int TDATA_W = 2 * DATA_W;

  // Configuration register widths and reset values.
  localparam int WL_W       = 7;
  localparam int KW         = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = WL_W;
  localparam logic [WL_W-1:0] WL_RESET = 7'd16;
  localparam logic [KW-1:0]   K_RESET  = 6'd4;

  // Numerator last*k + x - h fits 23 signed bits; its magnitude fits 22.
  localparam int NUM_W = 23;
  localparam int MAG_W = NUM_W - 1;
  localparam int DIFF_W = DATA_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH     = 1'd0,
    REG_SMOOTHING_DIVISOR = 1'd1
  } reg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_fill;  // store the request only, no result
    logic capture;     // latch the request and read the history
    logic mult;        // form last*k and x-h
    logic load;        // start both dividers
    logic write;       // load the output register and push the result
  } rws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_mode;
    logic div_busy;
    logic out_free;
  } rws_status_t;

endpackage
`default_nettype wire

[src/rws_div.sv]
`default_nettype none
// ============================================================================
// rws_div: bit-serial signed divider with 16-bit saturation
// Divides a signed numerator by a small positive divisor, one quotient bit
// per cycle, truncating toward zero, and saturates the quotient to 16 bits.
// ============================================================================
module rws_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [rws_pkg::NUM_W-1:0]   num,
  input  wire logic        [rws_pkg::KW-1:0]      den,
  output logic                                    busy,
  output logic signed [rws_pkg::DATA_W-1:0]       quot
);
  import rws_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);
  localparam logic signed [MAG_W:0] SAT_HI = (MAG_W+1)'((2 ** (DATA_W - 1)) - 1);
  localparam logic signed [MAG_W:0] SAT_LO = -SAT_HI - (MAG_W+1)'(1);

  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [KW-1:0]      den_r;
  logic [KW-1:0]      rem;
  logic [MAG_W-1:0]   q;
  logic [MAG_W-1:0]   mag_full;
  logic [KW:0]        rem_sh;
  logic               fits;
  logic signed [MAG_W:0] q_signed;

  // Magnitude of the numerator and the trial subtraction of one step.
  // The remainder stays below the divisor, so it fits the divisor width.
  always_comb begin
    mag_full = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    rem_sh   = {rem, q[MAG_W-1]};
    fits     = (rem_sh >= {1'b0, den_r});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // Restoring division on the magnitude, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      den_r <= den;
      rem   <= '0;
      q     <= mag_full;
    end else if (busy) begin
      rem <= fits ? KW'(rem_sh - {1'b0, den_r}) : rem_sh[KW-1:0];
      q   <= {q[MAG_W-2:0], fits};
    end
  end

  // Restore the sign and clamp to the 16-bit range.
  always_comb begin
    q_signed = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (q_signed > SAT_HI) begin
      quot = SAT_HI[DATA_W-1:0];
    end else if (q_signed < SAT_LO) begin
      quot = SAT_LO[DATA_W-1:0];
    end else begin
      quot = q_signed[DATA_W-1:0];
    end
  end

endmodule
`default_nettype wire

[src/rws_datapath.sv]
`default_nettype none
// ============================================================================
// rws_datapath: history memories, arithmetic and output register
// Holds the configuration, both coordinate histories, the fill count and
// the newest pointer, forms last*k + x - h per axis and divides it by k.
// ============================================================================
module rws_datapath #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [rws_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [rws_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [rws_pkg::TDATA_W-1:0]       s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [rws_pkg::TDATA_W-1:0]            m_tdata,
  input  wire rws_pkg::rws_cmd_t                 cmd,
  output rws_pkg::rws_status_t                   status
);
  import rws_pkg::*;

  localparam int PW   = $clog2(MAX_WINDOW);
  localparam int FC_W = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (FC_W > WL_W) ? FC_W : WL_W;
  localparam int AW   = ((PW > KW) ? PW : KW) + 1;

  // Configuration registers.
  logic [WL_W-1:0] window_length;
  logic [KW-1:0]   smoothing_divisor;

  // History state.
  logic [DATA_W-1:0] x_mem [MAX_WINDOW];
  logic [DATA_W-1:0] y_mem [MAX_WINDOW];
  logic [FC_W-1:0]   fill_count;
  logic [PW-1:0]     np;
  logic [PW-1:0]     np_next;
  logic [PW-1:0]     back;

  // Window and divisor after clamping.
  logic [CW-1:0] wl_e;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] w_m1;
  logic [KW-1:0] k_raw;
  logic [KW-1:0] k_eff;
  logic [AW-1:0] np_a;
  logic [AW-1:0] k_a;
  logic [AW-1:0] back_a;

  // Per-request registers.
  logic signed [DATA_W-1:0] x_in_r, y_in_r;
  logic signed [DATA_W-1:0] x_last, x_h, y_last, y_h;
  logic        [KW-1:0]     k_r;
  logic signed [KW:0]       k_s;
  logic signed [NUM_W-1:0]  x_prod, y_prod;
  logic signed [DIFF_W-1:0] x_diff, y_diff;
  logic signed [NUM_W-1:0]  x_num, y_num;
  logic signed [DATA_W-1:0] x_q, y_q;
  logic                     x_busy, y_busy;

  // Memory write port.
  logic              wr_en;
  logic [DATA_W-1:0] wr_x, wr_y;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WL_RESET;
      smoothing_divisor <= K_RESET;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_addr))
        REG_WINDOW_LENGTH:     window_length     <= cfg_wdata;
        REG_SMOOTHING_DIVISOR: smoothing_divisor <= cfg_wdata[KW-1:0];
        default:               window_length     <= window_length;
      endcase
    end
  end

  // Effective window, divisor and history addresses.
  always_comb begin
    wl_e = CW'(window_length);
    if (wl_e < CW'(2)) begin
      w_eff = CW'(2);
    end else if (wl_e > CW'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = wl_e;
    end
    w_m1  = w_eff - CW'(1);
    k_raw = (smoothing_divisor == '0) ? KW'(1) : smoothing_divisor;
    k_eff = (CW'(k_raw) > w_m1) ? w_m1[KW-1:0] : k_raw;

    np_a   = AW'(np);
    k_a    = AW'(k_eff);
    back_a = (np_a >= k_a) ? (np_a - k_a) : (np_a + AW'(MAX_WINDOW) - k_a);
    back   = back_a[PW-1:0];

    np_next = (np == PW'(MAX_WINDOW - 1)) ? '0 : (np + PW'(1));
  end

  // Fill count and newest pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      np         <= '0;
    end else begin
      if (cmd.store_fill) begin
        fill_count <= fill_count + FC_W'(1);
      end
      if (cmd.store_fill || cmd.write) begin
        np <= np_next;
      end
    end
  end

  // History memories: one write port, two registered read ports.
  assign wr_en = cmd.store_fill || cmd.write;
  assign wr_x  = cmd.store_fill ? s_tdata[DATA_W-1:0] : x_q;
  assign wr_y  = cmd.store_fill ? s_tdata[TDATA_W-1:DATA_W] : y_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[np_next] <= wr_x;
      y_mem[np_next] <= wr_y;
    end
    if (cmd.capture) begin
      x_last <= x_mem[np];
      x_h    <= x_mem[back];
      y_last <= y_mem[np];
      y_h    <= y_mem[back];
    end
  end

  // Request capture and the multiply stage.
  assign k_s = $signed({1'b0, k_r});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_in_r <= s_tdata[DATA_W-1:0];
      y_in_r <= s_tdata[TDATA_W-1:DATA_W];
      k_r    <= k_eff;
    end
    if (cmd.mult) begin
      x_prod <= NUM_W'(x_last * k_s);
      y_prod <= NUM_W'(y_last * k_s);
      x_diff <= DIFF_W'(x_in_r) - DIFF_W'(x_h);
      y_diff <= DIFF_W'(y_in_r) - DIFF_W'(y_h);
    end
  end

  // Numerators for the dividers.
  assign x_num = x_prod + NUM_W'(x_diff);
  assign y_num = y_prod + NUM_W'(y_diff);

  rws_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .num   (x_num),
    .den   (k_r),
    .busy  (x_busy),
    .quot  (x_q)
  );

  rws_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.load),
    .num   (y_num),
    .den   (k_r),
    .busy  (y_busy),
    .quot  (y_q)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.write) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      m_tdata <= {y_q, x_q};
    end
  end

  // Status to the controller.
  always_comb begin
    status.fill_mode = (CW'(fill_count) < w_eff);
    status.div_busy  = x_busy || y_busy;
    status.out_free  = !m_tvalid || m_tready;
  end

`ifndef SYNTH
  // A stored-only request never produces a result.
  a_fill_silent: assert property (@(posedge clk) disable iff (rst)
    cmd.store_fill |=> !$rose(m_tvalid))
    else $error("result appeared after a fill request");

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // The dividers are never restarted while working.
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(x_busy || y_busy))
    else $error("divider started while busy");

  // The fill count never passes the history depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FC_W'(MAX_WINDOW))
    else $error("fill count beyond history depth");
`endif

endmodule
`default_nettype wire

[src/rws_ctrl.sv]
`default_nettype none
// ============================================================================
// rws_ctrl: sequencing state machine of the recursive window smoother
// Accepts requests, stores fill requests directly and steps a smoothing
// request through capture, multiply, divide and write-back.
// ============================================================================
module rws_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire rws_pkg::rws_status_t  status,
  output rws_pkg::rws_cmd_t          cmd
);
  import rws_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MULT  = 5'b00010,
    S_LOAD  = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (status.fill_mode) begin
            cmd.store_fill = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_MULT;
          end
        end
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/recursive_window_smoother.sv]
`default_nettype none
// ============================================================================
// recursive_window_smoother: recursive moving-average X,Y smoother
// Stores the first window_length coordinate pairs, then returns one
// smoothed and saturated pair per request and feeds it back into history.
// ============================================================================
// A request that only fills the history is stored as it is taken and
// gives no result. A smoothing request occupies the block until the next
// request can be taken: the history is read as the request is taken, then
// the block multiplies, loads the dividers, runs the bit-serial dividers
// (one quotient bit per cycle, both axes in parallel), sees them finish,
// writes back and returns to idle, where the next request is taken. The
// result sits in an output register, so the next request is taken while
// it waits; write-back stalls only while an earlier result is still held
// there. The user must write configuration only while idle; the block
// itself does not enforce this.
module recursive_window_smoother #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write port.
  input  wire logic                              cfg_wen,
  input  wire logic [rws_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [rws_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input stream.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rws_pkg::TDATA_W-1:0]       s_tdata,  // x_in[15:0], y_in[31:16]
  // Output stream.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [rws_pkg::TDATA_W-1:0]            m_tdata   // x_out[15:0], y_out[31:16]
);
  import rws_pkg::*;

  rws_cmd_t    cmd;
  rws_status_t status;

  rws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rws_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

[tb/recursive_window_smoother_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// recursive_window_smoother_tb: self-checking bench for the X,Y smoother
// Streams coordinate pairs through the block under a series of window and
// divisor settings with varying back-pressure. A scoreboard predicts every
// smoothed pair and compares each delivered result against the oldest one.
// ============================================================================
module recursive_window_smoother_tb;
  import rws_pkg::*;

  localparam int HIST_DEPTH     = 64;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DIRECTED_FILLS = 16;
  localparam int PHASE_ITEMS    = 40;
  localparam int PHASE_COUNT    = 10;

  typedef struct {
    logic signed [DATA_W-1:0] x_out;
    logic signed [DATA_W-1:0] y_out;
  } smoothed_pair_t;

  // Scoreboard: mirrors the history buffers and holds the pairs still owed.
  class smoother_scoreboard;
    logic signed [DATA_W-1:0] x_hist [HIST_DEPTH];
    logic signed [DATA_W-1:0] y_hist [HIST_DEPTH];
    int unsigned    fill_count;
    int unsigned    newest;
    logic [WL_W-1:0] window_len;
    logic [KW-1:0]   divisor;
    smoothed_pair_t smoothed_q [$];
    int errors;
    int requests;
    int results;

    function new();
      fill_count = 0;
      newest     = 0;
      window_len = WL_RESET;
      divisor    = K_RESET;
      errors     = 0;
      requests   = 0;
      results    = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_WINDOW_LENGTH) begin
        window_len = value[WL_W-1:0];
      end else begin
        divisor = value[KW-1:0];
      end
    endfunction

    // One axis: (last*k + sample - oldest)/k, truncated toward zero, saturated.
    function logic signed [DATA_W-1:0] average_axis(logic signed [DATA_W-1:0] last,
                                                    logic signed [DATA_W-1:0] oldest,
                                                    logic signed [DATA_W-1:0] sample,
                                                    int unsigned k);
      longint num;
      longint quo;
      num = longint'(last) * longint'(k) + longint'(sample) - longint'(oldest);
      quo = num / longint'(k);
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      return quo[DATA_W-1:0];
    endfunction

    function void note_request(logic [TDATA_W-1:0] word);
      logic signed [DATA_W-1:0] xi;
      logic signed [DATA_W-1:0] yi;
      int unsigned w;
      int unsigned k;
      int unsigned back;
      smoothed_pair_t r;
      xi = word[DATA_W-1:0];
      yi = word[TDATA_W-1:DATA_W];
      requests++;
      w = window_len;
      if (w < 2) w = 2;
      if (w > HIST_DEPTH) w = HIST_DEPTH;
      // Filling: store only.
      if (fill_count < w) begin
        newest = (newest + 1) % HIST_DEPTH;
        x_hist[newest] = xi;
        y_hist[newest] = yi;
        fill_count++;
        return;
      end
      k = (divisor == 0) ? 1 : divisor;
      if (k > w - 1) k = w - 1;
      back = (newest + HIST_DEPTH - k) % HIST_DEPTH;
      r.x_out = average_axis(x_hist[newest], x_hist[back], xi, k);
      r.y_out = average_axis(y_hist[newest], y_hist[back], yi, k);
      // The result becomes the newest history entry.
      newest = (newest + 1) % HIST_DEPTH;
      x_hist[newest] = r.x_out;
      y_hist[newest] = r.y_out;
      smoothed_q.push_back(r);
    endfunction

    function void check_result(logic [TDATA_W-1:0] word);
      logic signed [DATA_W-1:0] xa;
      logic signed [DATA_W-1:0] ya;
      smoothed_pair_t e;
      xa = word[DATA_W-1:0];
      ya = word[TDATA_W-1:DATA_W];
      results++;
      if (smoothed_q.size() == 0) begin
        $error("unexpected result: x_out %0d, y_out %0d", xa, ya);
        errors++;
        return;
      end
      e = smoothed_q.pop_front();
      if (xa !== e.x_out) begin
        $error("x_out mismatch: expected %0d, got %0d", e.x_out, xa);
        errors++;
      end
      if (ya !== e.y_out) begin
        $error("y_out mismatch: expected %0d, got %0d", e.y_out, ya);
        errors++;
      end
    endfunction

    function int pending();
      return smoothed_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata;   // x_in[15:0], y_in[31:16]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_W-1:0]     m_tdata;   // x_out[15:0], y_out[31:16]

  smoother_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;
  int settings_used;

  recursive_window_smoother #(
    .MAX_WINDOW(HIST_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: every accepted request feeds the predictor, every result is checked.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_request(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Watchdog on cycles without any accepted request or result.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("recursive_window_smoother verification failed");
    $finish;
  end

  // Mostly full-range values, with the extremes and small values mixed in.
  function automatic logic signed [DATA_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = DATA_W'($urandom) << DATA_W | DATA_W'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {yv, xv};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Wait for every owed result, then for any trailing fill work to settle.
  task automatic drain();
    s_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wen   = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic apply_setting(logic [WL_W-1:0] wl, logic [KW-1:0] k);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_SMOOTHING_DIVISOR, {1'b0, k});
    settings_used++;
  endtask

  initial begin
    logic [WL_W-1:0] phase_wl [PHASE_COUNT];
    logic [KW-1:0]   phase_k  [PHASE_COUNT];
    int mode;
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_addr       = REG_WINDOW_LENGTH;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settings_used  = 1;
    board          = new();

    // Short windows with zero and oversized divisors, growth to the full
    // window (which forces a refill), out-of-range lengths, then random.
    phase_wl = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd2, 7'd20, 7'd0, 7'd0, 7'd0};
    phase_k  = '{6'd0, 6'd63, 6'd63, 6'd5, 6'd1, 6'd1, 6'd40, 6'd0, 6'd0, 6'd0};
    for (int p = 7; p < PHASE_COUNT; p++) begin
      phase_wl[p] = WL_W'($urandom_range(0, 127));
      phase_k[p]  = KW'($urandom_range(0, 63));
    end

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: fill the reset-size window with alternating extremes, then
    // push extreme samples through the default divisor.
    for (int i = 0; i < DIRECTED_FILLS; i++) begin
      if (i % 2 == 0) send_pair(16'sh7fff, 16'sh8000);
      else send_pair(16'sh8000, 16'sh7fff);
    end
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh0000, 16'shffff);
    send_pair(16'sh0001, 16'sh0000);
    send_pair(16'shffff, 16'sh0001);
    send_pair(16'sh5555, 16'shaaaa);
    send_pair(16'shaaaa, 16'sh5555);
    send_pair(16'sh8000, 16'sh7fff);
    drain();

    // Random phases; idling cycles through none, sender, receiver and both.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      apply_setting(phase_wl[p], phase_k[p]);
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 55 : (mode == 3) ? 31 : 0;
      recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 31 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_pair(rand_coord(), rand_coord());
      drain();
    end

    $display("Sent %0d coordinate pairs under %0d register settings; %0d smoothed pairs checked.",
             board.requests, settings_used, board.results);
    if (board.errors == 0) begin
      $display("recursive_window_smoother verification clean");
    end else begin
      $display("recursive_window_smoother verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rws_pkg.sv
src/rws_div.sv
src/rws_datapath.sv
src/rws_ctrl.sv
src/recursive_window_smoother.sv
tb/recursive_window_smoother_tb.sv
